>>> rtl/core/smsc_pkg.sv
// Shared types, constants and the phase-entry function of the sound module
// serial commander. No dependencies; all files but smsc_ram import it.
`default_nettype none

package smsc_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int WORD_BITS   = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BITCNT_W    = $clog2(WORD_BITS + 1);
  localparam int TIMER_W     = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int VOL_MAX     = 7;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PLAY   = 2'd1,
    OP_STOP   = 2'd2,
    OP_VOLUME = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_CODE   = 3'd0,
    REG_VOLUME_BASE = 3'd1,
    REG_MAX_TRACK   = 3'd2,
    REG_START_LOW   = 3'd3,
    REG_BIT_PHASE   = 3'd4,
    REG_RESET_LOW   = 3'd5,
    REG_BOOT_WAIT   = 3'd6,
    REG_GAP         = 3'd7
  } cfg_idx_t;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_RESET_LOW = 8'b0000_0010,
    PH_BOOT_WAIT = 8'b0000_0100,
    PH_START_LOW = 8'b0000_1000,
    PH_BIT_LOW   = 8'b0001_0000,
    PH_BIT_HOLD  = 8'b0010_0000,
    PH_BIT_HIGH  = 8'b0100_0000,
    PH_GAP       = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic clock_pin;
    logic data_pin;
    logic reset_pin;
    logic accepted;
    logic rejected;
    logic busy_res;
  } res_t;

  typedef struct packed {
    logic [15:0] stop_code;
    logic [15:0] volume_base;
    logic [15:0] max_track;
    logic [15:0] start_low_ticks;
    logic [11:0] bit_phase_ticks;
    logic [15:0] reset_low_ticks;
    logic [19:0] boot_wait_ticks;
    logic [15:0] gap_ticks;
  } cfg_t;

  // Queue entry: play flag and the command word
  typedef struct packed {
    logic        play;
    logic [15:0] word;
  } entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
    logic not_empty_next;
  } q_stat_t;

  typedef struct packed {
    logic clock_pin;
    logic data_pin;
    logic reset_pin;
    logic active;
  } seq_stat_t;

  typedef struct packed {
    phase_t             phase;
    logic [TIMER_W-1:0] timer;
    logic               clk_lv;
    logic               dat_lv;
    logic               rst_lv;
    logic               load_cnt;
  } run_t;

  // Enter a phase and fall through every phase whose duration is zero.
  // A zero bit phase sends the rest of the word at once; the gap entry then
  // drives all pins high, so the chain jumps straight to the gap.
  function automatic run_t run_from(phase_t start, cfg_t c, logic clk_lv,
                                    logic dat_lv, logic rst_lv, logic msb);
    run_t   r;
    phase_t ph;
    logic   done;
    ph         = start;
    done       = 1'b0;
    r.phase    = start;
    r.timer    = '0;
    r.clk_lv   = clk_lv;
    r.dat_lv   = dat_lv;
    r.rst_lv   = rst_lv;
    r.load_cnt = 1'b0;
    if (ph == PH_RESET_LOW) begin
      r.rst_lv = 1'b0;
      if (c.reset_low_ticks != '0) begin
        r.timer = TIMER_W'(c.reset_low_ticks);
        done    = 1'b1;
      end else begin
        ph = PH_BOOT_WAIT;
      end
    end
    if (!done && ph == PH_BOOT_WAIT) begin
      r.rst_lv = 1'b1;
      if (c.boot_wait_ticks != '0) begin
        r.timer = TIMER_W'(c.boot_wait_ticks);
        done    = 1'b1;
      end else begin
        ph = PH_START_LOW;
      end
    end
    if (!done && ph == PH_START_LOW) begin
      r.clk_lv   = 1'b0;
      r.load_cnt = 1'b1;
      if (c.start_low_ticks != '0) begin
        r.timer = TIMER_W'(c.start_low_ticks);
        done    = 1'b1;
      end else begin
        ph = PH_BIT_LOW;
      end
    end
    if (!done && ph == PH_BIT_LOW) begin
      r.clk_lv = 1'b0;
      if (c.bit_phase_ticks != '0) begin
        r.timer = TIMER_W'(c.bit_phase_ticks);
        done    = 1'b1;
      end else begin
        ph = PH_GAP;
      end
    end
    if (!done && ph == PH_BIT_HOLD) begin
      r.dat_lv = msb;
      if (c.bit_phase_ticks != '0) begin
        r.timer = TIMER_W'(c.bit_phase_ticks);
        done    = 1'b1;
      end else begin
        ph = PH_GAP;
      end
    end
    if (!done && ph == PH_BIT_HIGH) begin
      r.clk_lv = 1'b1;
      if (c.bit_phase_ticks != '0) begin
        r.timer = TIMER_W'({c.bit_phase_ticks, 1'b0});
        done    = 1'b1;
      end else begin
        ph = PH_GAP;
      end
    end
    if (!done && ph == PH_GAP) begin
      r.clk_lv = 1'b1;
      r.dat_lv = 1'b1;
      r.rst_lv = 1'b1;
      if (c.gap_ticks != '0) begin
        r.timer = TIMER_W'(c.gap_ticks);
        done    = 1'b1;
      end else begin
        ph = PH_IDLE;
      end
    end
    if (!done && ph == PH_IDLE) begin
      r.clk_lv = 1'b1;
      r.dat_lv = 1'b1;
      r.rst_lv = 1'b1;
      r.timer  = '0;
    end
    r.phase = ph;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/smsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module smsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/smsc_queue.sv
// Command queue: circular buffer in smsc_ram with the head entry always
// presented. Depends on smsc_pkg and smsc_ram.
`default_nettype none

module smsc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire smsc_pkg::entry_t push_entry,
  input  wire logic             pop,
  output smsc_pkg::entry_t      head_entry,
  output smsc_pkg::q_stat_t     q_stat
);
  import smsc_pkg::*;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             fwd;
  entry_t           fwd_entry;
  entry_t           rd_entry;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // The RAM is read every cycle at the head the next cycle will see
  assign head_next = pop ? ptr_inc(head) : head;

  always_comb begin
    count_next = count;
    if (push) begin
      count_next = count + CNT_W'(1);
    end else if (pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  smsc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata (push_entry),
    .raddr (head_next),
    .rdata (rd_entry)
  );

  // Write into the entry being read this cycle: forward the new word
  always_ff @(posedge clk) begin
    fwd_entry <= push_entry;
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= push && (tail == head_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      if (push) begin
        tail <= ptr_inc(tail);
      end
    end
  end

  assign head_entry            = fwd ? fwd_entry : rd_entry;
  assign q_stat.not_empty      = (count != '0);
  assign q_stat.full           = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.not_empty_next = (count_next != '0);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !(pop || count == CNT_W'(QUEUE_DEPTH)))
    else $error("push into full queue or with pop");

endmodule

`default_nettype wire

>>> rtl/core/smsc_sequencer.sv
// Timing sequencer: walks the reset, boot, start bit, data bits and gap
// phases on tick words and drives the pin levels. Depends on smsc_pkg.
`default_nettype none

module smsc_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tick,
  input  wire smsc_pkg::cfg_t   cfg,
  input  wire logic             q_not_empty,
  input  wire smsc_pkg::entry_t head_entry,
  output logic                  pop,
  output smsc_pkg::seq_stat_t   seq_stat
);
  import smsc_pkg::*;

  phase_t                phase;
  phase_t                phase_next;
  phase_t                after_ph;
  logic [TIMER_W-1:0]    timer;
  logic [TIMER_W-1:0]    timer_next;
  logic [TIMER_W-1:0]    timer_dec;
  logic [BITCNT_W-1:0]   bit_cnt;
  logic [BITCNT_W-1:0]   bit_cnt_next;
  logic [BITCNT_W-1:0]   cnt_dec;
  logic [WORD_BITS-1:0]  shift_word;
  logic [WORD_BITS-1:0]  shift_next;
  logic [31:0]           load_wide;
  logic                  clk_lv;
  logic                  dat_lv;
  logic                  rst_lv;
  logic                  clk_next;
  logic                  dat_next;
  logic                  rst_next;
  run_t                  r1;
  run_t                  r2;

  always_comb begin
    phase_next   = phase;
    timer_next   = timer;
    bit_cnt_next = bit_cnt;
    shift_next   = shift_word;
    clk_next     = clk_lv;
    dat_next     = dat_lv;
    rst_next     = rst_lv;
    pop          = 1'b0;
    after_ph     = PH_IDLE;
    cnt_dec      = bit_cnt;
    timer_dec    = (timer != '0) ? timer - TIMER_W'(1) : timer;
    load_wide    = 32'(head_entry.word);
    r1           = run_from(PH_IDLE, cfg, clk_lv, dat_lv, rst_lv, 1'b1);
    r2           = r1;
    if (tick) begin
      if (phase != PH_IDLE) begin
        if (timer_dec != '0) begin
          timer_next = timer_dec;
        end else begin
          case (phase)
            PH_RESET_LOW: after_ph = PH_BOOT_WAIT;
            PH_BOOT_WAIT: after_ph = PH_START_LOW;
            PH_START_LOW: after_ph = PH_BIT_LOW;
            PH_BIT_LOW:   after_ph = PH_BIT_HOLD;
            PH_BIT_HOLD:  after_ph = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
              shift_next   = {shift_word[WORD_BITS-2:0], 1'b0};
              cnt_dec      = (bit_cnt != '0) ? bit_cnt - BITCNT_W'(1) : bit_cnt;
              bit_cnt_next = cnt_dec;
              after_ph     = (cnt_dec != '0) ? PH_BIT_LOW : PH_GAP;
            end
            default: after_ph = PH_IDLE;
          endcase
          r1 = run_from(after_ph, cfg, clk_lv, dat_lv, rst_lv,
                        shift_next[WORD_BITS-1]);
          phase_next = r1.phase;
          timer_next = r1.timer;
          clk_next   = r1.clk_lv;
          dat_next   = r1.dat_lv;
          rst_next   = r1.rst_lv;
          if (r1.load_cnt) begin
            bit_cnt_next = BITCNT_W'(WORD_BITS);
          end
        end
      end
      // Sequencer free: start the next queued word on this same tick
      if (phase_next == PH_IDLE && q_not_empty) begin
        pop        = 1'b1;
        shift_next = load_wide[WORD_BITS-1:0];
        r2 = run_from(head_entry.play ? PH_RESET_LOW : PH_START_LOW, cfg,
                      clk_next, dat_next, rst_next, load_wide[WORD_BITS-1]);
        phase_next = r2.phase;
        timer_next = r2.timer;
        clk_next   = r2.clk_lv;
        dat_next   = r2.dat_lv;
        rst_next   = r2.rst_lv;
        if (r2.load_cnt) begin
          bit_cnt_next = BITCNT_W'(WORD_BITS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      timer      <= '0;
      bit_cnt    <= '0;
      shift_word <= '0;
      clk_lv     <= 1'b1;
      dat_lv     <= 1'b1;
      rst_lv     <= 1'b1;
    end else begin
      phase      <= phase_next;
      timer      <= timer_next;
      bit_cnt    <= bit_cnt_next;
      shift_word <= shift_next;
      clk_lv     <= clk_next;
      dat_lv     <= dat_next;
      rst_lv     <= rst_next;
    end
  end

  assign seq_stat.clock_pin = clk_next;
  assign seq_stat.data_pin  = dat_next;
  assign seq_stat.reset_pin = rst_next;
  assign seq_stat.active    = (phase_next != PH_IDLE);

  a_idle_pins_high: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (clk_lv && dat_lv && rst_lv && timer == '0))
    else $error("pins not at rest while idle");

  a_busy_timer: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (timer != '0))
    else $error("active phase with expired timer");

  a_pop_on_tick: assert property (@(posedge clk) disable iff (rst)
    pop |-> (tick && q_not_empty))
    else $error("queue popped outside a tick");

endmodule

`default_nettype wire

>>> rtl/core/sound_module_serial_commander.sv
// Sound module serial commander: two-wire command sender for a sound module.
// Depends on smsc_pkg, smsc_queue (with smsc_ram) and smsc_sequencer.
//
// Channels: cmd (valid/ready, cmd_t) takes one word per item: a one
// microsecond tick or a play, stop or set-volume command. res (valid/ready,
// res_t) returns exactly one word per item: the clock, data and reset pin
// levels after the item, whether a command was queued or dropped, and
// whether the sequencer or queue is still busy. cfg (valid/ready, always
// ready) writes the timing and code registers by index.
//
// The result word is registered and valid the cycle after the command word
// is taken. Throughput: one item per cycle while results are taken; the
// sequencer does constant work per tick and the queue RAM is read every
// cycle at the upcoming head address, with forwarding of a same-entry write.
// Commands go into a 16-entry queue; a full queue or a track above
// max_track drops the command.
//
// Reset: queue empty, sequencer idle, all pins high, registers at their
// defaults; no clearing pass. A stalled receiver holds the result word
// and cmd_ready drops until the word is taken.
`default_nettype none

module sound_module_serial_commander (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_ready,
  input  wire smsc_pkg::cmd_t                      cmd,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output smsc_pkg::res_t                           res,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire smsc_pkg::cfg_idx_t                  cfg_index,
  input  wire logic [smsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import smsc_pkg::*;

  cfg_t      cfg;
  q_stat_t   q_stat;
  seq_stat_t seq_stat;
  entry_t    new_entry;
  entry_t    head_entry;
  logic      accept;
  logic      tick;
  logic      is_cmd;
  logic      ok;
  logic      push;
  logic      pop;
  logic [2:0] vol;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_code       <= 16'hFFFF;
      cfg.volume_base     <= 16'hFFF0;
      cfg.max_track       <= 16'd512;
      cfg.start_low_ticks <= 16'd1950;
      cfg.bit_phase_ticks <= 12'd50;
      cfg.reset_low_ticks <= 16'd5000;
      cfg.boot_wait_ticks <= 20'd500000;
      cfg.gap_ticks       <= 16'd2000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STOP_CODE:   cfg.stop_code       <= cfg_data[15:0];
        REG_VOLUME_BASE: cfg.volume_base     <= cfg_data[15:0];
        REG_MAX_TRACK:   cfg.max_track       <= cfg_data[15:0];
        REG_START_LOW:   cfg.start_low_ticks <= cfg_data[15:0];
        REG_BIT_PHASE:   cfg.bit_phase_ticks <= cfg_data[11:0];
        REG_RESET_LOW:   cfg.reset_low_ticks <= cfg_data[15:0];
        REG_BOOT_WAIT:   cfg.boot_wait_ticks <= cfg_data[19:0];
        REG_GAP:         cfg.gap_ticks       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cmd_ready = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign tick      = accept && (cmd.operation == OP_TICK);
  assign is_cmd    = accept && (cmd.operation != OP_TICK);

  // Command decode; the word is fixed at queue time
  always_comb begin
    vol       = (cmd.value[7:0] > 8'(VOL_MAX)) ? 3'(VOL_MAX) : cmd.value[2:0];
    new_entry = '0;
    ok        = 1'b1;
    case (cmd.operation)
      OP_PLAY: begin
        ok             = (cmd.value <= cfg.max_track);
        new_entry.play = 1'b1;
        new_entry.word = cmd.value;
      end
      OP_STOP:   new_entry.word = cfg.stop_code;
      OP_VOLUME: new_entry.word = cfg.volume_base + 16'(vol);
      default: ;
    endcase
  end

  assign push = is_cmd && ok && !q_stat.full;

  smsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (new_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_stat     (q_stat)
  );

  smsc_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .cfg         (cfg),
    .q_not_empty (q_stat.not_empty),
    .head_entry  (head_entry),
    .pop         (pop),
    .seq_stat    (seq_stat)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      res.clock_pin <= seq_stat.clock_pin;
      res.data_pin  <= seq_stat.data_pin;
      res.reset_pin <= seq_stat.reset_pin;
      res.accepted  <= push;
      res.rejected  <= is_cmd && !push;
      res.busy_res  <= seq_stat.active || q_stat.not_empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb.sv
// Testbench for sound_module_serial_commander: drives command and register words,
// works out every result word in a behavioral predictor and checks it.
// Depends on smsc_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb;
  import smsc_pkg::*;

  localparam int LIMIT_NS   = 5_000_000;
  localparam int SHOW_LIMIT = 10;
  localparam int RAND_ITEMS = 50;
  localparam int WALK_TICKS = 30;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_ready;
  cmd_t                  cmd;
  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned src_idle;
  int unsigned sink_stall;
  int unsigned fail_count;

  // predictor copy of the registers, queue and sequencer
  cfg_t regs = {16'hFFFF, 16'hFFF0, 16'd512, 16'd1950, 12'd50, 16'd5000,
                20'd500000, 16'd2000};
  entry_t               cmd_fifo[$];
  phase_t               seq_phase = PH_IDLE;
  int unsigned          seq_timer;
  int unsigned          bits_left;
  logic [WORD_BITS-1:0] tx_word;
  logic                 lv_clk = 1'b1;
  logic                 lv_dat = 1'b1;
  logic                 lv_rst = 1'b1;
  res_t                 predicted_status[$];

  sound_module_serial_commander dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= sink_stall);
  end

  function automatic string show_levels(res_t s);
    return $sformatf("clk %b dat %b rst %b acc %b rej %b busy %b", s.clock_pin,
                     s.data_pin, s.reset_pin, s.accepted, s.rejected, s.busy_res);
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Sets the pins of a phase and returns its length in ticks.
  function automatic int unsigned phase_enter(phase_t p);
    case (p)
      PH_RESET_LOW: begin
        lv_rst = 1'b0;
        return regs.reset_low_ticks;
      end
      PH_BOOT_WAIT: begin
        lv_rst = 1'b1;
        return regs.boot_wait_ticks;
      end
      PH_START_LOW: begin
        lv_clk    = 1'b0;
        bits_left = WORD_BITS;
        return regs.start_low_ticks;
      end
      PH_BIT_LOW: begin
        lv_clk = 1'b0;
        return regs.bit_phase_ticks;
      end
      PH_BIT_HOLD: begin
        lv_dat = tx_word[WORD_BITS-1];
        return regs.bit_phase_ticks;
      end
      PH_BIT_HIGH: begin
        lv_clk = 1'b1;
        return 2 * regs.bit_phase_ticks;
      end
      default: begin
        lv_clk = 1'b1;
        lv_dat = 1'b1;
        lv_rst = 1'b1;
        return regs.gap_ticks;
      end
    endcase
  endfunction

  function automatic phase_t phase_after(phase_t p);
    case (p)
      PH_RESET_LOW: return PH_BOOT_WAIT;
      PH_BOOT_WAIT: return PH_START_LOW;
      PH_START_LOW: return PH_BIT_LOW;
      PH_BIT_LOW:   return PH_BIT_HOLD;
      PH_BIT_HOLD:  return PH_BIT_HIGH;
      PH_BIT_HIGH: begin
        tx_word = tx_word << 1;
        if (bits_left > 0) bits_left--;
        return (bits_left != 0) ? PH_BIT_LOW : PH_GAP;
      end
      default: return PH_IDLE;
    endcase
  endfunction

  // Enter p, falling through every phase of zero length.
  function automatic void settle_from(phase_t p);
    phase_t      ph;
    int unsigned span;
    bit          done;
    ph   = p;
    done = 1'b0;
    while (!done) begin
      seq_phase = ph;
      if (ph == PH_IDLE) begin
        lv_clk    = 1'b1;
        lv_dat    = 1'b1;
        lv_rst    = 1'b1;
        seq_timer = 0;
        done      = 1'b1;
      end else begin
        span = phase_enter(ph);
        if (span != 0) begin
          seq_timer = span;
          done      = 1'b1;
        end else begin
          ph = phase_after(ph);
        end
      end
    end
  endfunction

  function automatic void advance_commander(op_t op, logic [15:0] v);
    res_t       r;
    entry_t     e;
    logic       took;
    logic       dropped;
    logic [7:0] vol;
    took    = 1'b0;
    dropped = 1'b0;
    if (op == OP_TICK) begin
      if (seq_phase != PH_IDLE) begin
        if (seq_timer > 0) seq_timer--;
        if (seq_timer == 0) settle_from(phase_after(seq_phase));
      end
      // an idle sequencer picks up the next command on the same tick
      if (seq_phase == PH_IDLE && cmd_fifo.size() != 0) begin
        e       = cmd_fifo.pop_front();
        tx_word = e.word[WORD_BITS-1:0];
        settle_from(e.play ? PH_RESET_LOW : PH_START_LOW);
      end
    end else begin
      e.play = (op == OP_PLAY);
      case (op)
        OP_PLAY: e.word = v;
        OP_STOP: e.word = regs.stop_code;
        default: begin
          vol    = (v[7:0] > VOL_MAX) ? 8'(VOL_MAX) : v[7:0];
          e.word = regs.volume_base + 16'(vol);
        end
      endcase
      if ((op == OP_PLAY && v > regs.max_track) || cmd_fifo.size() >= QUEUE_DEPTH) begin
        dropped = 1'b1;
      end else begin
        cmd_fifo.push_back(e);
        took = 1'b1;
      end
    end
    r.clock_pin = lv_clk;
    r.data_pin  = lv_dat;
    r.reset_pin = lv_rst;
    r.accepted  = took;
    r.rejected  = dropped;
    r.busy_res  = (seq_phase != PH_IDLE) || (cmd_fifo.size() != 0);
    predicted_status.push_back(r);
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (predicted_status.size() == 0) begin
        log_failure({"result word with nothing expected: ", show_levels(res)});
      end else begin
        want = predicted_status.pop_front();
        if (res.clock_pin !== want.clock_pin || res.data_pin !== want.data_pin ||
            res.reset_pin !== want.reset_pin || res.accepted !== want.accepted ||
            res.rejected !== want.rejected || res.busy_res !== want.busy_res) begin
          log_failure({"expected ", show_levels(want), ", got ", show_levels(res)});
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is
  // taken with valid still high, so the caller sends again or lowers it.
  task automatic send_cmd(input op_t op, input logic [15:0] v);
    cmd_t w;
    w.operation = op;
    w.value     = v;
    if ($urandom_range(99) < src_idle) begin
      cmd_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    do @(posedge clk); while (!cmd_ready);
    advance_commander(op, v);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STOP_CODE:   regs.stop_code       = data[15:0];
      REG_VOLUME_BASE: regs.volume_base     = data[15:0];
      REG_MAX_TRACK:   regs.max_track       = data[15:0];
      REG_START_LOW:   regs.start_low_ticks = data[15:0];
      REG_BIT_PHASE:   regs.bit_phase_ticks = data[11:0];
      REG_RESET_LOW:   regs.reset_low_ticks = data[15:0];
      REG_BOOT_WAIT:   regs.boot_wait_ticks = data[19:0];
      REG_GAP:         regs.gap_ticks       = data[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_reg(REG_STOP_CODE, CFG_DATA_W'(c.stop_code));
    write_reg(REG_VOLUME_BASE, CFG_DATA_W'(c.volume_base));
    write_reg(REG_MAX_TRACK, CFG_DATA_W'(c.max_track));
    write_reg(REG_START_LOW, CFG_DATA_W'(c.start_low_ticks));
    write_reg(REG_BIT_PHASE, CFG_DATA_W'(c.bit_phase_ticks));
    write_reg(REG_RESET_LOW, CFG_DATA_W'(c.reset_low_ticks));
    write_reg(REG_BOOT_WAIT, CFG_DATA_W'(c.boot_wait_ticks));
    write_reg(REG_GAP, CFG_DATA_W'(c.gap_ticks));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle_idle();
    cmd_valid <= 1'b0;
    while (predicted_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Walk the sequencer for a while, then send whatever is left with every
  // duration zero so the queue empties in a few ticks.
  task automatic drain_sequencer();
    cfg_t        c;
    int unsigned n;
    n = 0;
    while ((seq_phase != PH_IDLE || cmd_fifo.size() != 0) && n < WALK_TICKS) begin
      send_cmd(OP_TICK, 16'($urandom));
      n++;
    end
    settle_idle();
    if (seq_phase != PH_IDLE || cmd_fifo.size() != 0) begin
      c                 = regs;
      c.start_low_ticks = 16'd0;
      c.bit_phase_ticks = 12'd0;
      c.reset_low_ticks = 16'd0;
      c.boot_wait_ticks = 20'd0;
      c.gap_ticks       = 16'd0;
      apply_cfg(c);
      while (seq_phase != PH_IDLE || cmd_fifo.size() != 0)
        send_cmd(OP_TICK, 16'($urandom));
      settle_idle();
    end
  endtask

  // Reset codes and range check; the words are fixed before the codes change.
  task automatic test_default_codes();
    cfg_t c;
    send_cmd(OP_PLAY, 16'd512);
    send_cmd(OP_PLAY, 16'd513);
    send_cmd(OP_PLAY, 16'hFFFF);
    send_cmd(OP_STOP, 16'h0000);
    send_cmd(OP_VOLUME, 16'h00FF);
    send_cmd(OP_VOLUME, 16'hAB03);
    settle_idle();
    c                 = regs;
    c.stop_code       = 16'h0000;
    c.volume_base     = 16'h0000;
    c.start_low_ticks = 16'd3;
    c.bit_phase_ticks = 12'd1;
    c.reset_low_ticks = 16'd2;
    c.boot_wait_ticks = 20'd2;
    c.gap_ticks       = 16'd2;
    apply_cfg(c);
    drain_sequencer();
  endtask

  // Fill the queue, overflow it, then drain with every duration zero.
  task automatic test_queue_full();
    cfg_t c;
    c.stop_code       = 16'h8001;
    c.volume_base     = 16'h1234;
    c.max_track       = 16'd512;
    c.start_low_ticks = 16'd0;
    c.bit_phase_ticks = 12'd0;
    c.reset_low_ticks = 16'd0;
    c.boot_wait_ticks = 20'd0;
    c.gap_ticks       = 16'd0;
    apply_cfg(c);
    send_cmd(OP_PLAY, 16'd7);
    repeat (QUEUE_DEPTH - 1) send_cmd(OP_STOP, 16'($urandom));
    send_cmd(OP_VOLUME, 16'h0008);
    send_cmd(OP_PLAY, 16'd0);
    drain_sequencer();
  endtask

  task automatic test_extremes();
    cfg_t c;
    c.stop_code       = 16'hFFFF;
    c.volume_base     = 16'hFFFF;
    c.max_track       = 16'hFFFF;
    c.start_low_ticks = 16'hFFFF;
    c.bit_phase_ticks = 12'hFFF;
    c.reset_low_ticks = 16'hFFFF;
    c.boot_wait_ticks = 20'hFFFFF;
    c.gap_ticks       = 16'hFFFF;
    apply_cfg(c);
    send_cmd(OP_PLAY, 16'hFFFF);
    send_cmd(OP_VOLUME, 16'hFF07);   // base + 7 wraps to 6
    send_cmd(OP_VOLUME, 16'h0008);
    send_cmd(OP_STOP, 16'hFFFF);
    settle_idle();
    c.max_track       = 16'd0;
    c.start_low_ticks = 16'd1;
    c.bit_phase_ticks = 12'd2;
    c.reset_low_ticks = 16'd1;
    c.boot_wait_ticks = 20'd0;
    c.gap_ticks       = 16'd0;
    apply_cfg(c);
    send_cmd(OP_PLAY, 16'd0);
    send_cmd(OP_PLAY, 16'd1);
    drain_sequencer();
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct);
    cfg_t        c;
    int unsigned pick;
    op_t         op;
    logic [15:0] v;
    src_idle          = idle_pct;
    sink_stall        = stall_pct;
    c.stop_code       = 16'($urandom);
    c.volume_base     = $urandom_range(1) ? 16'($urandom) : 16'hFFFF - 16'($urandom_range(7));
    case ($urandom_range(3))
      0:       c.max_track = 16'd0;
      1:       c.max_track = 16'd512;
      2:       c.max_track = 16'($urandom);
      default: c.max_track = 16'hFFFF;
    endcase
    pick              = $urandom_range(3);
    c.bit_phase_ticks = (pick == 0) ? 12'd0 : (pick == 3) ? 12'd2 : 12'd1;
    c.start_low_ticks = 16'($urandom_range(3));
    c.reset_low_ticks = 16'($urandom_range(3));
    c.boot_wait_ticks = 20'($urandom_range(4));
    c.gap_ticks       = 16'($urandom_range(3));
    apply_cfg(c);
    repeat (RAND_ITEMS) begin
      pick = $urandom_range(99);
      // keep the queue short mostly, with an occasional burst into a full queue
      if (pick < 80 || (cmd_fifo.size() > 2 && pick < 96)) begin
        send_cmd(OP_TICK, 16'($urandom));
      end else begin
        op = op_t'($urandom_range(3, 1));
        if (op == OP_PLAY && $urandom_range(2) != 0)
          v = 16'($urandom_range(regs.max_track, 0));
        else if (op == OP_VOLUME && $urandom_range(1) != 0)
          v = {8'($urandom), 8'($urandom_range(9))};
        else
          v = 16'($urandom);
        send_cmd(op, v);
      end
    end
    drain_sequencer();
  endtask

  initial begin
    #(LIMIT_NS);
    $display("sound_module_serial_commander test failed");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    res_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_STOP_CODE;
    cfg_data   = '0;
    src_idle   = 0;
    sink_stall = 0;
    fail_count = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_default_codes();
    test_queue_full();
    test_extremes();
    test_random(0, 0);
    test_random(84, 0);
    test_random(0, 84);
    test_random(10, 10);

    settle_idle();
    if (fail_count == 0) begin
      $display("sound_module_serial_commander test passed");
    end else begin
      $display("sound_module_serial_commander test failed");
    end
    $finish;
  end

endmodule
